@@ hw/rtl/i2crw_pkg.sv @@
`timescale 1ns / 1ps

package i2crw_pkg;

    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned TRIES_W = 4;
    localparam int unsigned GAP_W   = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BCNT_W  = 4;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [ADDR_W-1:0]  RST_DEVICE_ADDRESS = 7'h42;
    localparam logic [TRIES_W-1:0] RST_MAX_TRIES      = 4'd3;
    localparam logic [GAP_W-1:0]   RST_RETRY_GAP      = 8'd40;

    localparam logic [BCNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_ADDR  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_REG   = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_VALUE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_MAX_TRIES      = 2'd1,
        CFG_RETRY_GAP      = 2'd2
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_TICK    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  device_address;
        logic [TRIES_W-1:0] max_tries;
        logic [GAP_W-1:0]   retry_gap;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] register_index;
        logic [BYTE_W-1:0] write_value;
        logic              sda_sampled;
    } item_t;

    typedef struct packed {
        logic scl_drive_low;
        logic sda_drive_low;
        logic busy;
        logic done;
        logic failed;
    } result_t;

    typedef enum logic [19:0] {
        PH_IDLE      = 20'h00001,
        PH_ST_SDA_HI = 20'h00002,
        PH_ST_SCL_HI = 20'h00004,
        PH_ST_SDA_LO = 20'h00008,
        PH_ST_WAIT   = 20'h00010,
        PH_ST_SCL_LO = 20'h00020,
        PH_BIT_SDA   = 20'h00040,
        PH_BIT_SCL_H = 20'h00080,
        PH_BIT_SCL_L = 20'h00100,
        PH_AK_SDA_R  = 20'h00200,
        PH_AK_WAIT   = 20'h00400,
        PH_AK_SCL_H  = 20'h00800,
        PH_AK_SCL_L  = 20'h01000,
        PH_AK_SDA_R2 = 20'h02000,
        PH_SP_SDA_LO = 20'h04000,
        PH_SP_WAIT1  = 20'h08000,
        PH_SP_SCL_HI = 20'h10000,
        PH_SP_WAIT2  = 20'h20000,
        PH_SP_SDA_HI = 20'h40000,
        PH_GAP       = 20'h80000
    } phase_t;

endpackage

@@ hw/rtl/i2c_register_write_master_unit.sv @@
`timescale 1ns / 1ps

// Open-drain I2C register write master. A request transaction latches a
// register index and a value; each following tick transaction advances the
// bus by one half-bit phase (start, address byte with write bit, register
// byte, value byte, ACK slots, stop, retry gap) and carries the SDA level
// sampled for that phase. Every input transaction yields exactly one result
// transaction with the pin drives after that phase plus busy/done/failed.
// A QUEUE_DEPTH-entry queue sits between the input and the sequencer; the
// input takes one transaction per clock until the queue is full, also while
// a result waits on m_ready. The sequencer steps once per clock unless the
// queue is empty or a result waits on m_ready, and registers the result as
// it takes a transaction. Configuration writes (cfg_index 0 device address,
// 1 tries, 2 retry gap) are always accepted and must only happen while idle.
module i2c_register_write_master_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2crw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2crw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [i2crw_pkg::BYTE_W-1:0]        s_register_index,
    input  logic [i2crw_pkg::BYTE_W-1:0]        s_write_value,
    input  logic                                s_sda_sampled,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_scl_drive_low,
    output logic                                m_sda_drive_low,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic                                m_failed
);
    import i2crw_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    result_t  result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= RST_DEVICE_ADDRESS;
            cfg_reg.max_tries      <= RST_MAX_TRIES;
            cfg_reg.retry_gap      <= RST_RETRY_GAP;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[ADDR_W-1:0];
                CFG_MAX_TRIES:      cfg_reg.max_tries      <= cfg_data[TRIES_W-1:0];
                CFG_RETRY_GAP:      cfg_reg.retry_gap      <= cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    i2crw_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_register_index (s_register_index),
        .s_write_value    (s_write_value),
        .s_sda_sampled    (s_sda_sampled),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop)
    );

    i2crw_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_scl_drive_low = result.scl_drive_low;
    assign m_sda_drive_low = result.sda_drive_low;
    assign m_busy_res      = result.busy;
    assign m_done_res      = result.done;
    assign m_failed        = result.failed;

endmodule

@@ hw/rtl/i2crw_front.sv @@
`timescale 1ns / 1ps

module i2crw_front #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [i2crw_pkg::BYTE_W-1:0]      s_register_index,
    input  logic [i2crw_pkg::BYTE_W-1:0]      s_write_value,
    input  logic                              s_sda_sampled,
    output logic                              q_valid,
    output i2crw_pkg::item_t                  q_item,
    input  logic                              q_pop
);
    import i2crw_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    item_t             in_item;
    logic              push;

    // request and tick are told apart here; payload of a tick keeps only the sample
    always_comb begin
        in_item.op             = (s_operation == 1'b1) ? OP_REQUEST : OP_TICK;
        in_item.register_index = (s_operation == 1'b1) ? s_register_index : '0;
        in_item.write_value    = (s_operation == 1'b1) ? s_write_value : '0;
        in_item.sda_sampled    = s_sda_sampled;
    end

    assign s_ready = (count_reg != FULL_CNT);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (q_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/i2crw_seq.sv @@
`timescale 1ns / 1ps

module i2crw_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  i2crw_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  i2crw_pkg::item_t   q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output i2crw_pkg::result_t m_result
);
    import i2crw_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BCNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TRIES_W-1:0]  tries_reg, tries_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [BYTE_W-1:0]   held_reg_reg, held_reg_next;
    logic [BYTE_W-1:0]   held_val_reg, held_val_next;
    logic [GAP_W-1:0]    gap_reg, gap_next;
    logic                ack_reg, ack_next;
    logic                scl_low_reg, scl_low_next;
    logic                sda_low_reg, sda_low_next;
    logic                out_valid_reg;
    result_t             out_reg, out_next;

    logic [TRIES_W-1:0]  tries_inc;
    logic                tries_out;
    logic [BCNT_W-1:0]   bit_inc;
    logic [GAP_W-1:0]    gap_dec;
    logic [SLOT_W-1:0]   slot_inc;
    logic [BYTE_W-1:0]   addr_byte;
    logic [BYTE_W-1:0]   slot_byte;
    logic                done, fail;

    assign q_pop    = q_valid && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    assign tries_inc = tries_reg + 1'b1;
    assign tries_out = (tries_inc >= cfg.max_tries);
    assign bit_inc   = bit_cnt_reg + 1'b1;
    assign gap_dec   = gap_reg - 1'b1;
    assign slot_inc  = slot_reg + 1'b1;
    assign addr_byte = {cfg.device_address, 1'b0};
    assign slot_byte = (slot_inc == SLOT_REG) ? held_reg_reg : held_val_reg;

    always_comb begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        slot_next     = slot_reg;
        tries_next    = tries_reg;
        shift_next    = shift_reg;
        held_reg_next = held_reg_reg;
        held_val_next = held_val_reg;
        gap_next      = gap_reg;
        ack_next      = ack_reg;
        scl_low_next  = scl_low_reg;
        sda_low_next  = sda_low_reg;
        done          = 1'b0;
        fail          = 1'b0;

        if (q_item.op == OP_REQUEST) begin
            if (phase_reg == PH_IDLE) begin
                held_reg_next = q_item.register_index;
                held_val_next = q_item.write_value;
                tries_next    = '0;
                slot_next     = SLOT_ADDR;
                bit_cnt_next  = '0;
                ack_next      = 1'b0;
                gap_next      = '0;
                phase_next    = PH_ST_SDA_HI;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_ST_SDA_HI: begin
                    sda_low_next = 1'b0;
                    phase_next   = PH_ST_SCL_HI;
                end
                PH_ST_SCL_HI: begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_ST_SDA_LO;
                end
                PH_ST_SDA_LO: begin
                    sda_low_next = 1'b1;
                    phase_next   = PH_ST_WAIT;
                end
                PH_ST_WAIT: begin
                    phase_next = PH_ST_SCL_LO;
                end
                PH_ST_SCL_LO: begin
                    scl_low_next = 1'b1;
                    ack_next     = 1'b0;
                    slot_next    = SLOT_ADDR;
                    bit_cnt_next = '0;
                    shift_next   = addr_byte;
                    phase_next   = PH_BIT_SDA;
                end
                PH_BIT_SDA: begin
                    sda_low_next = !shift_reg[BYTE_W-1];
                    phase_next   = PH_BIT_SCL_H;
                end
                PH_BIT_SCL_H: begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_BIT_SCL_L;
                end
                PH_BIT_SCL_L: begin
                    scl_low_next = 1'b1;
                    shift_next   = {shift_reg[BYTE_W-2:0], 1'b0};
                    bit_cnt_next = bit_inc;
                    phase_next   = (bit_inc >= BITS_PER_BYTE) ? PH_AK_SDA_R : PH_BIT_SDA;
                end
                PH_AK_SDA_R: begin
                    sda_low_next = 1'b0;
                    phase_next   = PH_AK_WAIT;
                end
                PH_AK_WAIT: begin
                    phase_next = PH_AK_SCL_H;
                end
                PH_AK_SCL_H: begin
                    scl_low_next = 1'b0;
                    ack_next     = !q_item.sda_sampled;
                    phase_next   = PH_AK_SCL_L;
                end
                PH_AK_SCL_L: begin
                    scl_low_next = 1'b1;
                    phase_next   = PH_AK_SDA_R2;
                end
                PH_AK_SDA_R2: begin
                    sda_low_next = 1'b0;
                    if (slot_reg >= SLOT_VALUE || !ack_reg) begin
                        phase_next = PH_SP_SDA_LO;
                    end else begin
                        slot_next    = slot_inc;
                        bit_cnt_next = '0;
                        shift_next   = slot_byte;
                        phase_next   = PH_BIT_SDA;
                    end
                end
                PH_SP_SDA_LO: begin
                    sda_low_next = 1'b1;
                    phase_next   = PH_SP_WAIT1;
                end
                PH_SP_WAIT1: begin
                    phase_next = PH_SP_SCL_HI;
                end
                PH_SP_SCL_HI: begin
                    scl_low_next = 1'b0;
                    phase_next   = PH_SP_WAIT2;
                end
                PH_SP_WAIT2: begin
                    phase_next = PH_SP_SDA_HI;
                end
                PH_SP_SDA_HI: begin
                    sda_low_next = 1'b0;
                    if (slot_reg >= SLOT_VALUE && ack_reg) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end else if (slot_reg >= SLOT_VALUE && cfg.retry_gap != '0) begin
                        gap_next   = cfg.retry_gap;
                        phase_next = PH_GAP;
                    end else begin
                        tries_next = tries_inc;
                        done       = tries_out;
                        fail       = tries_out;
                        phase_next = tries_out ? PH_IDLE : PH_ST_SDA_HI;
                    end
                end
                PH_GAP: begin
                    gap_next = gap_dec;
                    if (gap_dec == '0) begin
                        tries_next = tries_inc;
                        done       = tries_out;
                        fail       = tries_out;
                        phase_next = tries_out ? PH_IDLE : PH_ST_SDA_HI;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        out_next.scl_drive_low = scl_low_next;
        out_next.sda_drive_low = sda_low_next;
        out_next.busy          = (phase_next != PH_IDLE);
        out_next.done          = done;
        out_next.failed        = fail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            slot_reg      <= '0;
            tries_reg     <= '0;
            shift_reg     <= '0;
            held_reg_reg  <= '0;
            held_val_reg  <= '0;
            gap_reg       <= '0;
            ack_reg       <= 1'b0;
            scl_low_reg   <= 1'b0;
            sda_low_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg    <= phase_next;
                bit_cnt_reg  <= bit_cnt_next;
                slot_reg     <= slot_next;
                tries_reg    <= tries_next;
                shift_reg    <= shift_next;
                held_reg_reg <= held_reg_next;
                held_val_reg <= held_val_next;
                gap_reg      <= gap_next;
                ack_reg      <= ack_next;
                scl_low_reg  <= scl_low_next;
                sda_low_reg  <= sda_low_next;
            end
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ hw/rtl/i2crw_checker.sv @@
`timescale 1ns / 1ps

module i2crw_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_scl_drive_low,
    input logic m_sda_drive_low,
    input logic m_busy_res,
    input logic m_done_res,
    input logic m_failed
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl_drive_low)
            && $stable(m_sda_drive_low) && $stable(m_busy_res)
            && $stable(m_done_res) && $stable(m_failed))
        else $error("result changed while stalled");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done with busy still set");

    a_fail_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failed |-> m_done_res)
        else $error("failed without done");

    a_done_bus_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_scl_drive_low && !m_sda_drive_low)
        else $error("bus not released at end of transaction");

endmodule

bind i2c_register_write_master_unit i2crw_checker u_i2crw_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_scl_drive_low (m_scl_drive_low),
    .m_sda_drive_low (m_sda_drive_low),
    .m_busy_res      (m_busy_res),
    .m_done_res      (m_done_res),
    .m_failed        (m_failed)
);
